// ----- hdl/smvp_pkg.sv -----
// Shared types, codes and saturating arithmetic for the sparse matrix-vector product core.
package smvp_pkg;

    localparam int MODE_W  = 3;
    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD_VECTOR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_PRIOR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NONZERO     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EMPTY_ROW   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_START       = 3'd4;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd32768);

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic                    ovf;
    } smvp_sat_t;

    // finished row on its way from the accumulator to rounding
    typedef struct packed {
        logic [INDEX_W-1:0]      row;
        logic signed [ACC_W-1:0] sum;
        logic                    clip;
        logic [VALUE_W-1:0]      prior;
    } smvp_close_t;

    function automatic smvp_sat_t sat_add64(input logic signed [ACC_W-1:0] a,
                                            input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        smvp_sat_t               r;
        s     = a + b;
        r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
        if (r.ovf)
        begin
            r.sum = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            r.sum = s;
        end
        return r;
    endfunction

endpackage

// ----- hdl/smvp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module smvp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/smvp_idx_mod.sv -----
// Reduces a 12-bit index modulo a constant store depth.
module smvp_idx_mod
    import smvp_pkg::*;
#(
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic [INDEX_W-1:0] idx,
    output logic [AW-1:0]      addr
);

    logic [INDEX_W-1:0] rem;

    // shifted-divisor subtraction; steps whose divisor exceeds the index range drop out
    always_comb
    begin
        longint step;
        rem = idx;
        for (int k = INDEX_W - 1; k >= 0; k--)
        begin
            step = longint'(DEPTH) << k;
            if ((step < (longint'(1) << INDEX_W)) && (longint'(rem) >= step))
            begin
                rem = rem - INDEX_W'(step);
            end
        end
    end

    assign addr = AW'(rem);

endmodule

// ----- hdl/smvp_row_close.sv -----
// Row close pipeline: prior-output add, rounding, clipping and result register.
module smvp_row_close
    import smvp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accumulate_mode,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  smvp_close_t               item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [INDEX_W-1:0]        row,
    output logic signed [VALUE_W-1:0] result_value,
    output logic                      saturated
);

    logic        s3_valid_reg, s3_valid_next;
    smvp_close_t s3_item_reg;

    logic                    s4_valid_reg, s4_valid_next;
    logic signed [ACC_W-1:0] s4_sum_reg;
    logic                    s4_clip_reg;
    logic [INDEX_W-1:0]      s4_row_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]        row_reg;
    logic signed [VALUE_W-1:0] result_reg;
    logic                      sat_reg;

    logic can_out, can_4, can_3;

    logic signed [ACC_W-1:0]         prior_ext;
    smvp_sat_t                       prior_sum;
    logic signed [ACC_W-1:0]         s4_sum_next;
    logic                            s4_clip_next;
    smvp_sat_t                       rounded;
    logic signed [ACC_W-FRAC_W-1:0]  quot;
    logic                            q_hi, q_lo;
    logic signed [VALUE_W-1:0]       result_next;
    logic                            sat_next;

    assign can_out  = !out_valid_reg || out_ready;
    assign can_4    = !s4_valid_reg || can_out;
    assign can_3    = !s3_valid_reg || can_4;
    assign in_ready = can_3;

    // prior output is Q16.16, accumulator Q32.32
    assign prior_ext = {{(ACC_W-VALUE_W-FRAC_W){s3_item_reg.prior[VALUE_W-1]}},
                        s3_item_reg.prior, {FRAC_W{1'b0}}};
    assign prior_sum = sat_add64(s3_item_reg.sum, prior_ext);

    always_comb
    begin
        if (accumulate_mode)
        begin
            s4_sum_next  = prior_sum.sum;
            s4_clip_next = s3_item_reg.clip || prior_sum.ovf;
        end
        else
        begin
            s4_sum_next  = s3_item_reg.sum;
            s4_clip_next = s3_item_reg.clip;
        end
    end

    // round half up, floor shift, clip to 32 bits
    assign rounded = sat_add64(s4_sum_reg, ROUND_HALF);
    assign quot    = rounded.sum[ACC_W-1:FRAC_W];
    assign q_hi    = !quot[ACC_W-FRAC_W-1] && (|quot[ACC_W-FRAC_W-2:VALUE_W-1]);
    assign q_lo    = quot[ACC_W-FRAC_W-1] && !(&quot[ACC_W-FRAC_W-2:VALUE_W-1]);

    always_comb
    begin
        priority if (q_hi)
        begin
            result_next = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (q_lo)
        begin
            result_next = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            result_next = quot[VALUE_W-1:0];
        end
        sat_next = s4_clip_reg || rounded.ovf || q_hi || q_lo;
    end

    assign s3_valid_next  = can_3 ? in_valid : s3_valid_reg;
    assign s4_valid_next  = can_4 ? s3_valid_reg : s4_valid_reg;
    assign out_valid_next = can_out ? s4_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_3)
        begin
            s3_item_reg <= item;
        end
        if (can_4)
        begin
            s4_sum_reg  <= s4_sum_next;
            s4_clip_reg <= s4_clip_next;
            s4_row_reg  <= s3_item_reg.row;
        end
        if (can_out)
        begin
            row_reg    <= s4_row_reg;
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row          = row_reg;
    assign result_value = result_reg;
    assign saturated    = sat_reg;

endmodule

// ----- hdl/sparse_matrix_vector_product_core.sv -----
// Sparse matrix-vector product core: y = A*x (+ y_prior) in saturating Q16.16.
//
// Usage: load x with mode 0 items and, for accumulation, prior outputs with mode 1
// items (both addressed by index). Send a start item (mode 4) to reset the row
// count and accumulator, then stream nonzeros (mode 2) in row order with the column
// in index and row_last on the final nonzero of each row; an empty row is a mode 3
// item. Each closed row yields one result transfer carrying row, result_value and
// saturated. accumulate_mode is written via cfg_write_en/cfg_write_data; the user must
// write it only while idle, which the block does not enforce. Both channels are
// valid/ready. One item is taken per cycle while in_ready is high. The item that closes
// a row passes registers s1 to s4; the output register then holds its result. The rate
// is set by the vector store's single read port, one column read per item. When the
// receiver stalls, the pipeline stages fill and in_ready falls only once every stage
// holds an item. Reset clears the pipeline, the accumulator, the row count and
// accumulate_mode; the two stores are not cleared and must be loaded before use.
module sparse_matrix_vector_product_core
    import smvp_pkg::*;
#(
    parameter int VECTOR_DEPTH = 4096,
    parameter int ROW_DEPTH    = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic                      cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [MODE_W-1:0]         mode,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      row_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [INDEX_W-1:0]        row,
    output logic signed [VALUE_W-1:0] result_value,
    output logic                      saturated
);

    localparam int VAW = $clog2(VECTOR_DEPTH);
    localparam int RAW = $clog2(ROW_DEPTH);
    localparam logic [RAW-1:0] ROW_TOP = RAW'(ROW_DEPTH - 1);

    logic accumulate_mode_reg, accumulate_mode_next;

    logic           accept;
    logic           in_closes;
    logic [RAW-1:0] row_cnt_reg, row_cnt_next;

    logic [VAW-1:0]     vec_waddr_rd;
    logic [RAW-1:0]     prior_waddr;
    logic [VALUE_W-1:0] vec_rdata;
    logic [VALUE_W-1:0] prior_rdata;

    logic                      s1_valid_reg, s1_valid_next;
    logic [MODE_W-1:0]         s1_mode_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;
    logic                      s1_last_reg;
    logic [INDEX_W-1:0]        s1_row_reg;

    logic                    s2_valid_reg, s2_valid_next;
    logic [MODE_W-1:0]       s2_mode_reg;
    logic                    s2_last_reg;
    logic [INDEX_W-1:0]      s2_row_reg;
    logic signed [ACC_W-1:0] s2_prod_reg;
    logic [VALUE_W-1:0]      s2_prior_reg;

    logic signed [ACC_W-1:0] product;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    clip_reg, clip_next;
    logic signed [ACC_W-1:0] addend;
    smvp_sat_t               acc_sum;
    logic                    s2_closes;
    logic                    s2_leaves;

    logic        close_valid;
    logic        close_ready;
    smvp_close_t close_item;

    logic can_1, can_2;

    assign can_2    = !s2_valid_reg || close_ready;
    assign can_1    = !s1_valid_reg || can_2;
    assign in_ready = can_1;
    assign accept   = in_valid && can_1;

    assign accumulate_mode_next = cfg_write_en ? cfg_write_data : accumulate_mode_reg;

    // issue-side row count: the row an item belongs to is known at transfer
    assign in_closes = ((mode == MODE_NONZERO) && row_last) || (mode == MODE_EMPTY_ROW);

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            priority if (mode == MODE_START)
            begin
                row_cnt_next = '0;
            end
            else if (in_closes)
            begin
                row_cnt_next = (row_cnt_reg == ROW_TOP) ? '0 : row_cnt_reg + 1'b1;
            end
            else
            begin
                row_cnt_next = row_cnt_reg;
            end
        end
    end

    smvp_idx_mod #(
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_mod (
        .idx  (index),
        .addr (vec_waddr_rd)
    );

    smvp_idx_mod #(
        .DEPTH (ROW_DEPTH)
    ) u_prior_mod (
        .idx  (index),
        .addr (prior_waddr)
    );

    smvp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_ram (
        .clk   (clk),
        .we    (accept && (mode == MODE_LOAD_VECTOR)),
        .waddr (vec_waddr_rd),
        .wdata (value),
        .re    (can_1),
        .raddr (vec_waddr_rd),
        .rdata (vec_rdata)
    );

    smvp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ROW_DEPTH)
    ) u_prior_ram (
        .clk   (clk),
        .we    (accept && (mode == MODE_LOAD_PRIOR)),
        .waddr (prior_waddr),
        .wdata (value),
        .re    (can_1),
        .raddr (row_cnt_reg),
        .rdata (prior_rdata)
    );

    assign product = s1_value_reg * $signed(vec_rdata);

    // accumulate stage
    assign s2_closes = ((s2_mode_reg == MODE_NONZERO) && s2_last_reg)
                       || (s2_mode_reg == MODE_EMPTY_ROW);
    assign s2_leaves = s2_valid_reg && close_ready;
    assign addend    = (s2_mode_reg == MODE_NONZERO) ? s2_prod_reg : '0;
    assign acc_sum   = sat_add64(acc_reg, addend);

    always_comb
    begin
        acc_next  = acc_reg;
        clip_next = clip_reg;
        if (s2_leaves)
        begin
            priority if (s2_closes || (s2_mode_reg == MODE_START))
            begin
                acc_next  = '0;
                clip_next = 1'b0;
            end
            else if (s2_mode_reg == MODE_NONZERO)
            begin
                acc_next  = acc_sum.sum;
                clip_next = clip_reg || acc_sum.ovf;
            end
            else
            begin
                acc_next  = acc_reg;
                clip_next = clip_reg;
            end
        end
    end

    assign close_valid      = s2_valid_reg && s2_closes;
    assign close_item.row   = s2_row_reg;
    assign close_item.sum   = acc_sum.sum;
    assign close_item.clip  = clip_reg || acc_sum.ovf;
    assign close_item.prior = s2_prior_reg;

    assign s1_valid_next = can_1 ? in_valid : s1_valid_reg;
    assign s2_valid_next = can_2 ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulate_mode_reg <= 1'b0;
            row_cnt_reg         <= '0;
            s1_valid_reg        <= 1'b0;
            s2_valid_reg        <= 1'b0;
            acc_reg             <= '0;
            clip_reg            <= 1'b0;
        end
        else
        begin
            accumulate_mode_reg <= accumulate_mode_next;
            row_cnt_reg         <= row_cnt_next;
            s1_valid_reg        <= s1_valid_next;
            s2_valid_reg        <= s2_valid_next;
            acc_reg             <= acc_next;
            clip_reg            <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_1)
        begin
            s1_mode_reg  <= mode;
            s1_value_reg <= value;
            s1_last_reg  <= row_last;
            s1_row_reg   <= INDEX_W'(row_cnt_reg);
        end
        if (can_2)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_last_reg  <= s1_last_reg;
            s2_row_reg   <= s1_row_reg;
            s2_prod_reg  <= product;
            s2_prior_reg <= prior_rdata;
        end
    end

    smvp_row_close u_row_close (
        .clk             (clk),
        .rst_n           (rst_n),
        .accumulate_mode (accumulate_mode_reg),
        .in_valid        (close_valid),
        .in_ready        (close_ready),
        .item            (close_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row             (row),
        .result_value    (result_value),
        .saturated       (saturated)
    );

endmodule

// ----- bench/tb_sparse_matrix_vector_product_core.sv -----
// Self-checking testbench for the sparse matrix-vector product core.
`timescale 1ns / 1ps

module tb_sparse_matrix_vector_product_core;
    import smvp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 12;
    localparam int HOLD_TICKS   = 60;

    typedef struct packed {
        logic [INDEX_W-1:0] row;
        logic [VALUE_W-1:0] value;
        logic               sat;
    } row_result_t;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_TYPED,
        STEP_CONFIG
    } step_kind_t;

    typedef struct packed {
        step_kind_t         kind;
        logic [MODE_W-1:0]  m;
        logic [INDEX_W-1:0] ix;
        logic [VALUE_W-1:0] v;
        logic               lst;
        row_result_t        want;
    } step_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic                      cfg_write_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_last;
    logic                      out_valid;
    logic                      out_ready;
    logic [INDEX_W-1:0]        row;
    logic signed [VALUE_W-1:0] result_value;
    logic                      saturated;

    // predictor state
    logic [VALUE_W-1:0]      x_mem [0:4095];
    logic [VALUE_W-1:0]      y_prior_mem [0:4095];
    logic signed [ACC_W-1:0] row_sum;
    logic [INDEX_W-1:0]      row_count;
    bit                      row_clipped;
    bit                      accumulate_on;

    // which store entries hold data, so nothing unwritten is ever read
    bit prior_ok [0:4095];
    bit col_ok [0:4095];
    int loaded_cols [$];

    row_result_t expected_rows [$];
    row_result_t want_row;
    step_t       directed_plan [$];

    bit idle_on;
    bit hold_req;
    int mismatches;
    int quiet_cycles;

    sparse_matrix_vector_product_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .index          (index),
        .value          (value),
        .row_last       (row_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row            (row),
        .result_value   (result_value),
        .saturated      (saturated)
    );

    always #4 clk = ~clk;

    function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b,
                                                        output bit ovf);
        logic signed [ACC_W:0] s;
        s   = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        ovf = (s[ACC_W] != s[ACC_W-1]);
        if (!ovf)
        begin
            return s[ACC_W-1:0];
        end
        return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    function automatic row_result_t finish_row();
        logic signed [ACC_W-1:0]   t;
        logic signed [ACC_W-1:0]   q;
        logic [VALUE_W-1:0]        p;
        bit                        clip;
        bit                        ovf;
        row_result_t               res;
        t    = row_sum;
        clip = row_clipped;
        if (accumulate_on)
        begin
            p    = y_prior_mem[row_count];
            t    = sat_sum(t, {{16{p[31]}}, p, 16'h0000}, ovf);
            clip = clip | ovf;
        end
        t    = sat_sum(t, 64'sd32768, ovf);
        clip = clip | ovf;
        q    = t >>> FRAC_W;   // floor division
        if (q > 64'sd2147483647)
        begin
            res.value = 32'h7FFF_FFFF;
            clip      = 1'b1;
        end
        else if (q < -64'sd2147483648)
        begin
            res.value = 32'h8000_0000;
            clip      = 1'b1;
        end
        else
        begin
            res.value = q[VALUE_W-1:0];
        end
        res.row     = row_count;
        res.sat     = clip;
        row_count   = row_count + 1'b1;
        row_sum     = '0;
        row_clipped = 1'b0;
        return res;
    endfunction

    // one accepted item; returns 1 when it closes a row
    function automatic bit spmv_step(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] ix,
                                     input logic [VALUE_W-1:0] v, input logic lst,
                                     output row_result_t res);
        logic signed [ACC_W-1:0] prod;
        bit                      ovf;
        res = '0;
        case (m)
            MODE_LOAD_VECTOR:
            begin
                x_mem[ix] = v;
                if (!col_ok[ix])
                begin
                    col_ok[ix] = 1'b1;
                    loaded_cols.push_back(ix);
                end
            end
            MODE_LOAD_PRIOR:
            begin
                y_prior_mem[ix] = v;
                prior_ok[ix]    = 1'b1;
            end
            MODE_NONZERO:
            begin
                prod        = $signed(v) * $signed(x_mem[ix]);
                row_sum     = sat_sum(row_sum, prod, ovf);
                row_clipped = row_clipped | ovf;
                if (lst)
                begin
                    res = finish_row();
                    return 1'b1;
                end
            end
            MODE_EMPTY_ROW:
            begin
                res = finish_row();
                return 1'b1;
            end
            MODE_START:
            begin
                row_count   = '0;
                row_sum     = '0;
                row_clipped = 1'b0;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return 32'($urandom_range(0, 20'hFFFFF)) - 32'h0008_0000;
            4: return 32'h0001_0000 + 32'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_col();
        return INDEX_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    endfunction

    function automatic void plan(step_kind_t k, logic [MODE_W-1:0] m, logic [INDEX_W-1:0] ix,
                                 logic [VALUE_W-1:0] v, logic lst, logic [INDEX_W-1:0] wr,
                                 logic [VALUE_W-1:0] wv, logic ws);
        step_t s;
        s.kind       = k;
        s.m          = m;
        s.ix         = ix;
        s.v          = v;
        s.lst        = lst;
        s.want.row   = wr;
        s.want.value = wv;
        s.want.sat   = ws;
        directed_plan.push_back(s);
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] ix,
                             input logic [VALUE_W-1:0] v, input logic lst,
                             output bit got, output row_result_t pred);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = m;
        index    = ix;
        value    = v;
        row_last = lst;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        got = spmv_step(m, ix, v, lst, pred);
    endtask

    task automatic send(input logic [MODE_W-1:0] m, input logic [INDEX_W-1:0] ix,
                        input logic [VALUE_W-1:0] v, input logic lst);
        bit          got;
        row_result_t pred;
        send_item(m, ix, v, lst, got, pred);
        if (got)
        begin
            expected_rows.push_back(pred);
        end
    endtask

    // stop offering items, let every row result drain, then let the pipe settle
    task automatic drain_rows();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_accumulate(input bit on);
        drain_rows();
        @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = on;
        @(posedge clk);
        accumulate_on = on;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic send_row(input int n, input bit unclosed);
        int k;
        if (accumulate_on && !prior_ok[row_count])
        begin
            send(MODE_LOAD_PRIOR, row_count, pick_value(), 1'($urandom));
        end
        if (n == 0)
        begin
            send(MODE_EMPTY_ROW, 12'($urandom), $urandom, 1'($urandom));
        end
        for (k = 0; k < n; k++)
        begin
            send(MODE_NONZERO, pick_col(), pick_value(), (k == n - 1) && !unclosed);
        end
        if (unclosed)
        begin
            send(MODE_EMPTY_ROW, 12'($urandom), $urandom, 1'($urandom));
        end
    endtask

    task automatic random_phase(input int n_items, input bit acc, input bit with_hold,
                                input bit with_pause);
        int                 sent;
        int                 iter;
        int                 pick;
        int                 n;
        logic [INDEX_W-1:0] ix;
        write_accumulate(acc);
        sent = 0;
        iter = 0;
        while (sent < n_items)
        begin
            if (iter % 40 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (with_hold && iter == 40)
            begin
                // receiver holds off while empty rows keep coming: the pipe fills
                hold_req = 1'b1;
                repeat (30) send(MODE_EMPTY_ROW, 12'($urandom), $urandom, 1'($urandom));
                sent += 30;
            end
            if (with_pause && iter == 40)
            begin
                drain_rows();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                case ($urandom_range(0, 5))
                    0: ix = '0;
                    1: ix = '1;
                    2: ix = pick_col();
                    default: ix = 12'($urandom);
                endcase
                send(MODE_LOAD_VECTOR, ix, pick_value(), 1'($urandom));
                sent++;
            end
            else if (pick < 13)
            begin
                ix = $urandom_range(0, 1) ? row_count + 12'($urandom_range(0, 7))
                                          : 12'($urandom);
                send(MODE_LOAD_PRIOR, ix, pick_value(), 1'($urandom));
                sent++;
            end
            else if (pick < 16)
            begin
                send(MODE_START, 12'($urandom), $urandom, 1'($urandom));
                sent++;
            end
            else if (pick < 18)
            begin
                // unused codes are ignored by the block
                send(3'($urandom_range(5, 7)), 12'($urandom), $urandom, 1'($urandom));
            end
            else
            begin
                n = $urandom_range(0, 5);
                send_row(n, n > 0 && $urandom_range(0, 19) == 0);
                sent += n + 1;
            end
            iter++;
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_TICKS) @(negedge clk);
                hold_req  = 1'b0;
                out_ready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row result: row %0d, result_value %h", row, result_value);
                mismatches++;
            end
            else
            begin
                want_row = expected_rows.pop_front();
                if (row !== want_row.row)
                begin
                    $error("row: expected %0d, actual %0d", want_row.row, row);
                    mismatches++;
                end
                if (result_value !== want_row.value)
                begin
                    $error("result_value: expected %h, actual %h", want_row.value, result_value);
                    mismatches++;
                end
                if (saturated !== want_row.sat)
                begin
                    $error("saturated: expected %0b, actual %0b", want_row.sat, saturated);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        step_t       s;
        bit          got;
        row_result_t pred;
        int          r;
        int          n;
        int          k;

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_LOAD_VECTOR;
        index          = '0;
        value          = '0;
        row_last       = 1'b0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        row_sum        = '0;
        row_count      = '0;
        row_clipped    = 1'b0;
        accumulate_on  = 1'b0;

        // kind, mode, index, value, row_last, expected row, value, saturated
        plan(STEP_TYPED, MODE_EMPTY_ROW, 12'd0, 32'h0, 1'b0, 12'd0, 32'h0, 1'b0);
        plan(STEP_ITEM, MODE_LOAD_VECTOR, 12'hFFF, 32'h7FFF_FFFF, 1'b1, 0, 0, 0);
        plan(STEP_TYPED, MODE_NONZERO, 12'hFFF, 32'h8000_0000, 1'b1, 12'd1, 32'h8000_0000, 1'b1);
        plan(STEP_ITEM, MODE_LOAD_VECTOR, 12'd0, 32'h8000_0000, 1'b0, 0, 0, 0);
        plan(STEP_ITEM, MODE_NONZERO, 12'd0, 32'h8000_0000, 1'b0, 0, 0, 0);
        // two products of 2^62 overflow the accumulator
        plan(STEP_TYPED, MODE_NONZERO, 12'd0, 32'h8000_0000, 1'b1, 12'd2, 32'h7FFF_FFFF, 1'b1);
        plan(STEP_ITEM, MODE_LOAD_VECTOR, 12'd1, 32'h0001_0000, 1'b0, 0, 0, 0);
        plan(STEP_ITEM, MODE_NONZERO, 12'd1, 32'h0002_0000, 1'b1, 0, 0, 0);
        plan(STEP_ITEM, MODE_LOAD_VECTOR, 12'd2, 32'h0000_0001, 1'b0, 0, 0, 0);
        // exact halves, positive and negative; both round up
        plan(STEP_ITEM, MODE_NONZERO, 12'd2, 32'h0000_8000, 1'b1, 0, 0, 0);
        plan(STEP_ITEM, MODE_NONZERO, 12'd2, 32'hFFFF_8000, 1'b1, 0, 0, 0);
        plan(STEP_ITEM, 3'd5, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 0, 0, 0);
        plan(STEP_ITEM, 3'd6, 12'h555, 32'hAAAA_AAAA, 1'b0, 0, 0, 0);
        plan(STEP_ITEM, 3'd7, 12'hAAA, 32'h5555_5555, 1'b1, 0, 0, 0);
        // open row closed by an empty-row item
        plan(STEP_ITEM, MODE_NONZERO, 12'd1, 32'hFFFF_0000, 1'b0, 0, 0, 0);
        plan(STEP_ITEM, MODE_EMPTY_ROW, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 0, 0, 0);
        plan(STEP_ITEM, MODE_START, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 0, 0, 0);
        plan(STEP_TYPED, MODE_EMPTY_ROW, 12'd0, 32'h0, 1'b0, 12'd0, 32'h0, 1'b0);
        plan(STEP_ITEM, MODE_LOAD_PRIOR, 12'd0, 32'h7FFF_FFFF, 1'b0, 0, 0, 0);
        plan(STEP_ITEM, MODE_LOAD_PRIOR, 12'd1, 32'h8000_0000, 1'b1, 0, 0, 0);
        plan(STEP_ITEM, MODE_LOAD_PRIOR, 12'hFFF, 32'h0001_8000, 1'b0, 0, 0, 0);
        plan(STEP_CONFIG, MODE_START, 12'd0, 32'h1, 1'b0, 0, 0, 0);
        plan(STEP_ITEM, MODE_START, 12'd0, 32'h0, 1'b0, 0, 0, 0);
        plan(STEP_TYPED, MODE_EMPTY_ROW, 12'd0, 32'h0, 1'b0, 12'd0, 32'h7FFF_FFFF, 1'b0);
        plan(STEP_TYPED, MODE_NONZERO, 12'hFFF, 32'h8000_0000, 1'b1, 12'd1, 32'h8000_0000, 1'b1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[i])
        begin
            s = directed_plan[i];
            if (s.kind == STEP_CONFIG)
            begin
                write_accumulate(s.v[0]);
            end
            else
            begin
                send_item(s.m, s.ix, s.v, s.lst, got, pred);
                if (got)
                begin
                    expected_rows.push_back(s.kind == STEP_TYPED ? s.want : pred);
                end
            end
        end

        random_phase(350, 1'b0, 1'b1, 1'b0);
        random_phase(350, 1'b1, 1'b0, 1'b1);
        random_phase(300, 1'b0, 1'b0, 1'b0);

        // no idling from here on; rows back to back
        write_accumulate(1'b1);
        write_accumulate(1'b0);
        idle_on = 1'b0;
        for (r = 0; r < 100; r++)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                send_row(0, 1'b0);
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                begin
                    send(MODE_NONZERO, pick_col(), pick_value(), k == n - 1);
                end
            end
        end

        drain_rows();
        if (mismatches == 0 && expected_rows.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
